[hdl/assert_macros.svh]
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SGI_ASSERT_SAME(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("same-cycle property failed");

// The consequent must hold in the cycle after the antecedent.
`define SGI_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("next-cycle property failed");

`endif

[hdl/sgi_pkg.sv]
// ---------------------------------------------------------------------------
// sgi_pkg
// Types, codes and saturating helpers of the gravity integrator.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package sgi_pkg;

    localparam int unsigned WORD_W = 64;
    localparam int unsigned CFG_W  = 63;

    localparam logic [WORD_W-1:0] SIGN64 = {1'b1, {(WORD_W-1){1'b0}}};
    localparam logic [WORD_W-1:0] MAX64  = {1'b0, {(WORD_W-1){1'b1}}};

    typedef enum logic [1:0] {
        OP_PULL    = 2'd0,
        OP_ADVANCE = 2'd1,
        OP_LOAD    = 2'd2,
        OP_DEACT   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        CFG_GRAVITY   = 2'd0,
        CFG_SOFTENING = 2'd1,
        CFG_TIME_STEP = 2'd2,
        CFG_UNUSED    = 2'd3
    } t_cfg_index;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ,
        ST_S,
        ST_SQRT,
        ST_DEN,
        ST_GM,
        ST_NUM,
        ST_DIV,
        ST_ADT,
        ST_T,
        ST_VDT,
        ST_OUT
    } t_state;

    // Start strobes toward the shared serial units.
    typedef struct packed {
        logic mul;
        logic sqrt;
        logic div;
    } t_unit_start;

    function automatic logic [WORD_W-1:0] mag64(input logic [WORD_W-1:0] x);
        mag64 = x[WORD_W-1] ? (~x + 1'b1) : x;
    endfunction

    function automatic logic [WORD_W-1:0] from_mag64(input logic neg,
                                                    input logic [WORD_W-1:0] m);
        if (neg) begin
            from_mag64 = m[WORD_W-1] ? SIGN64 : (~m + 1'b1);
        end else begin
            from_mag64 = m[WORD_W-1] ? MAX64 : m;
        end
    endfunction

    function automatic logic [WORD_W-1:0] sat_add64(input logic [WORD_W-1:0] a,
                                                   input logic [WORD_W-1:0] b);
        logic [WORD_W-1:0] r;
        r = a + b;
        if ((a[WORD_W-1] == b[WORD_W-1]) && (r[WORD_W-1] != a[WORD_W-1])) begin
            sat_add64 = a[WORD_W-1] ? SIGN64 : MAX64;
        end else begin
            sat_add64 = r;
        end
    endfunction

endpackage

[hdl/sgi_mul.sv]
// ---------------------------------------------------------------------------
// sgi_mul
// Serial shift-add multiplier, one multiplier bit per cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sgi_mul import sgi_pkg::*; #(
    parameter int unsigned AW = 128,
    parameter int unsigned BW = 64
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [AW-1:0]  i_a,
    input  logic [BW-1:0]  i_b,
    output logic           o_done,
    output logic [AW+BW-1:0] o_p
);
    localparam int unsigned CW = $clog2(BW);

    logic [AW-1:0]    r_a;
    logic [BW-1:0]    r_b;
    logic [AW+BW-1:0] r_p;
    logic [CW-1:0]    r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [AW:0]      w_sum;

    // Partial sum is added into the upper half, then the product shifts right.
    assign w_sum = {1'b0, r_p[AW+BW-1:BW]} + (r_b[0] ? {1'b0, r_a} : {(AW+1){1'b0}});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(BW-1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_a;
            r_b <= i_b;
            r_p <= '0;
        end else if (r_busy) begin
            r_b <= r_b >> 1;
            r_p <= {w_sum, r_p[BW-1:1]};
        end
    end

    assign o_done = r_done;
    assign o_p    = r_p;
endmodule

[hdl/sgi_sqrt.sv]
// ---------------------------------------------------------------------------
// sgi_sqrt
// Digit-by-digit integer square root, one root bit per cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sgi_sqrt import sgi_pkg::*; #(
    parameter int unsigned W = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [2*W-1:0] i_x,
    output logic          o_done,
    output logic [W-1:0]  o_root
);
    localparam int unsigned CW = $clog2(W);

    logic [2*W-1:0] r_x;
    logic [W+1:0]   r_rem;
    logic [W-1:0]   r_root;
    logic [CW-1:0]  r_cnt;
    logic           r_busy;
    logic           r_done;
    logic [W+1:0]   w_rem2;
    logic [W+1:0]   w_trial;
    logic           w_ge;

    assign w_rem2  = {r_rem[W-1:0], r_x[2*W-1:2*W-2]};
    assign w_trial = {r_root, 2'b01};
    assign w_ge    = (w_rem2 >= w_trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(W-1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= i_x;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_x    <= r_x << 2;
            r_rem  <= w_ge ? (w_rem2 - w_trial) : w_rem2;
            r_root <= {r_root[W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;
endmodule

[hdl/sgi_div.sv]
// ---------------------------------------------------------------------------
// sgi_div
// Restoring divider with a saturated quotient, one quotient bit per cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sgi_div import sgi_pkg::*; #(
    parameter int unsigned DW = 128,
    parameter int unsigned QW = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DW+QW-1:0] i_num,
    input  logic [DW-1:0]    i_den,
    output logic             o_done,
    output logic [QW-1:0]    o_q
);
    localparam int unsigned CW = $clog2(QW);

    logic [DW-1:0] r_den;
    logic [DW-1:0] r_rem;
    logic [QW-1:0] r_low;
    logic [QW-1:0] r_q;
    logic          r_over;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [DW:0]   w_rem2;
    logic          w_ge;
    logic [DW:0]   w_diff;

    assign w_rem2 = {r_rem, r_low[QW-1]};
    assign w_ge   = (w_rem2 >= {1'b0, r_den});
    assign w_diff = w_rem2 - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(QW-1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // A quotient of QW bits overflows exactly when the high part reaches den.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den  <= i_den;
            r_rem  <= i_num[DW+QW-1:QW];
            r_low  <= i_num[QW-1:0];
            r_over <= (i_num[DW+QW-1:QW] >= i_den);
            r_q    <= '0;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[DW-1:0] : w_rem2[DW-1:0];
            r_low <= r_low << 1;
            r_q   <= {r_q[QW-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_q    = r_over ? {QW{1'b1}} : r_q;
endmodule

[hdl/softened_gravity_integrator_unit.sv]
// ---------------------------------------------------------------------------
// softened_gravity_integrator_unit
// One body's state with softened-gravity pull accumulation and Euler step.
// ---------------------------------------------------------------------------
// Usage: the input channel (i_valid/o_ready) carries an op and its operands;
// the output channel (o_valid/i_ready) returns one item per input item with
// the full body state after the op. The configuration channel (always ready)
// writes G, softening and dt; the user must write them only while the block
// is idle, which the block itself does not enforce.
// All arithmetic runs through three bit-serial units: a shift-add multiplier,
// a square root and a divider; each run starts on a strobe and ends on done.
// A load or deactivate, a pull or advance on an inactive body and a pull
// from an inactive body go straight to the output register; a pull whose
// softened distance is zero skips the square root and the divisions.
// One item is in work at a time.
// The finished result sits in an output register, so the next item is
// accepted while the receiver stalls; a later result waits for that register.
// Reset clears the body to zero with the active flag set and loads the
// default configuration.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module softened_gravity_integrator_unit import sgi_pkg::*; #(
    parameter int unsigned FRACTION_BITS = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [1:0]              i_op,
    input  logic signed [63:0]      i_in_x,
    input  logic signed [63:0]      i_in_y,
    input  logic signed [63:0]      i_in_z,
    input  logic signed [63:0]      i_in_vx,
    input  logic signed [63:0]      i_in_vy,
    input  logic signed [63:0]      i_in_vz,
    input  logic [62:0]             i_other_mass,
    input  logic                    i_other_active,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic signed [63:0]      o_pos_x,
    output logic signed [63:0]      o_pos_y,
    output logic signed [63:0]      o_pos_z,
    output logic signed [63:0]      o_vel_x,
    output logic signed [63:0]      o_vel_y,
    output logic signed [63:0]      o_vel_z,
    output logic signed [63:0]      o_acc_x,
    output logic signed [63:0]      o_acc_y,
    output logic signed [63:0]      o_acc_z,
    output logic                    o_is_active,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [1:0]              i_cfg_index,
    input  logic [62:0]             i_cfg_data
);
    localparam int unsigned MA = 128;
    localparam int unsigned MB = 64;
    localparam int unsigned SUM_W = 130;

    t_state r_state, n_state;
    logic   r_wait, n_wait;
    logic [1:0] r_ax, n_ax;
    logic [63:0] r_pos [3];
    logic [63:0] n_pos [3];
    logic [63:0] r_vel [3];
    logic [63:0] n_vel [3];
    logic [63:0] r_acc [3];
    logic [63:0] n_acc [3];
    logic [63:0] r_m [3];
    logic [63:0] n_m [3];
    logic [2:0]  r_ng, n_ng;
    logic        r_active, n_active;
    logic [62:0] r_mass, n_mass;
    logic [SUM_W-1:0] r_sum, n_sum;
    logic [63:0] r_s, n_s;
    logic [63:0] r_r, n_r;
    logic [127:0] r_den, n_den;
    logic [127:0] r_gm, n_gm;
    logic [63:0] r_adt, n_adt;
    logic [63:0] r_half, n_half;
    logic [62:0] r_grav, r_soft, r_dt;
    logic [63:0] r_o_pos [3];
    logic [63:0] r_o_vel [3];
    logic [63:0] r_o_acc [3];
    logic        r_o_active;
    logic        r_o_valid;
    logic        w_load_out;

    t_unit_start w_start;
    logic [MA-1:0] w_mul_a;
    logic [MB-1:0] w_mul_b;
    logic [MA+MB-1:0] w_mul_p;
    logic          w_mul_done;
    logic [63:0]   w_root;
    logic          w_sqrt_done;
    logic [63:0]   w_q;
    logic          w_div_done;
    logic          w_unit_done;
    logic [63:0]   w_mulq;
    logic [SUM_W:0] w_sw;
    logic [63:0]   w_snew;
    logic [63:0]   w_t;
    logic [63:0]   w_vdt;
    logic [64:0]   w_diff [3];
    logic [63:0]   w_in_pos [3];

    assign w_in_pos[0] = i_in_x;
    assign w_in_pos[1] = i_in_y;
    assign w_in_pos[2] = i_in_z;

    // Product of a Q value with a magnitude, shifted back and saturated.
    assign w_mulq = (|(w_mul_p >> (FRACTION_BITS + 64))) ? {64{1'b1}}
                                                         : w_mul_p[FRACTION_BITS +: 64];
    assign w_sw   = {1'b0, (r_sum >> FRACTION_BITS)} + {{(SUM_W-62){1'b0}}, r_soft};
    assign w_snew = (|w_sw[SUM_W:64]) ? {64{1'b1}} : w_sw[63:0];
    assign w_t    = from_mag64(r_adt[63], w_mulq);
    assign w_vdt  = from_mag64(r_vel[r_ax][63], w_mulq);

    assign o_ready     = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_load_out  = (r_state == ST_OUT) && (!r_o_valid || i_ready);

    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        case (r_state)
            ST_SQ: begin
                w_mul_a = {64'd0, r_m[r_ax]};
                w_mul_b = r_m[r_ax];
            end
            ST_DEN: begin
                w_mul_a = {64'd0, r_s};
                w_mul_b = r_r;
            end
            ST_GM: begin
                w_mul_a = {65'd0, r_grav};
                w_mul_b = {1'b0, r_mass};
            end
            ST_NUM: begin
                w_mul_a = r_gm;
                w_mul_b = r_m[r_ax];
            end
            ST_ADT: begin
                w_mul_a = {64'd0, mag64(r_acc[r_ax])};
                w_mul_b = {1'b0, r_dt};
            end
            ST_T: begin
                w_mul_a = {64'd0, mag64(r_adt)};
                w_mul_b = {1'b0, r_dt};
            end
            ST_VDT: begin
                w_mul_a = {64'd0, mag64(r_vel[r_ax])};
                w_mul_b = {1'b0, r_dt};
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    always_comb begin
        w_start.mul  = 1'b0;
        w_start.sqrt = 1'b0;
        w_start.div  = 1'b0;
        w_unit_done  = w_mul_done;
        if (!r_wait) begin
            case (r_state)
                ST_SQ, ST_DEN, ST_GM, ST_NUM, ST_ADT, ST_T, ST_VDT: w_start.mul = 1'b1;
                ST_SQRT: w_start.sqrt = 1'b1;
                ST_DIV:  w_start.div  = 1'b1;
                default: w_start.mul  = 1'b0;
            endcase
        end
        if (r_state == ST_SQRT) begin
            w_unit_done = w_sqrt_done;
        end else if (r_state == ST_DIV) begin
            w_unit_done = w_div_done;
        end
    end

    for (genvar g = 0; g < 3; g++) begin : g_diff
        assign w_diff[g] = {w_in_pos[g][63], w_in_pos[g]} - {r_pos[g][63], r_pos[g]};
    end

    always_comb begin
        n_state  = r_state;
        n_wait   = r_wait;
        n_ax     = r_ax;
        n_pos    = r_pos;
        n_vel    = r_vel;
        n_acc    = r_acc;
        n_m      = r_m;
        n_ng     = r_ng;
        n_active = r_active;
        n_mass   = r_mass;
        n_sum    = r_sum;
        n_s      = r_s;
        n_r      = r_r;
        n_den    = r_den;
        n_gm     = r_gm;
        n_adt    = r_adt;
        n_half   = r_half;
        if (w_start != '0) begin
            n_wait = 1'b1;
        end
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_ax    = 2'd0;
                    n_state = ST_OUT;
                    case (t_op'(i_op))
                        OP_PULL: begin
                            if (r_active && i_other_active) begin
                                for (int k = 0; k < 3; k++) begin
                                    // The sign of the 65-bit difference gives the direction.
                                    n_ng[k] = w_diff[k][64];
                                    n_m[k]  = w_diff[k][64] ? (~w_diff[k][63:0] + 1'b1)
                                                            : w_diff[k][63:0];
                                end
                                n_mass  = i_other_mass;
                                n_sum   = '0;
                                n_state = ST_SQ;
                            end
                        end
                        OP_ADVANCE: begin
                            if (r_active) begin
                                n_state = ST_ADT;
                            end
                        end
                        OP_LOAD: begin
                            n_pos[0] = i_in_x;
                            n_pos[1] = i_in_y;
                            n_pos[2] = i_in_z;
                            n_vel[0] = i_in_vx;
                            n_vel[1] = i_in_vy;
                            n_vel[2] = i_in_vz;
                            for (int k = 0; k < 3; k++) begin
                                n_acc[k] = '0;
                            end
                            n_active = 1'b1;
                        end
                        default: begin
                            n_active = 1'b0;
                        end
                    endcase
                end
            end
            ST_SQ: begin
                if (r_wait && w_unit_done) begin
                    n_wait = 1'b0;
                    n_sum  = r_sum + {2'b00, w_mul_p[127:0]};
                    if (r_ax == 2'd2) begin
                        n_state = ST_S;
                    end else begin
                        n_ax = r_ax + 2'd1;
                    end
                end
            end
            ST_S: begin
                n_s = w_snew;
                n_state = (w_snew == 64'd0) ? ST_OUT : ST_SQRT;
            end
            ST_SQRT: begin
                if (r_wait && w_unit_done) begin
                    n_wait  = 1'b0;
                    n_r     = w_root;
                    n_state = ST_DEN;
                end
            end
            ST_DEN: begin
                if (r_wait && w_unit_done) begin
                    n_wait  = 1'b0;
                    n_den   = w_mul_p[127:0];
                    n_state = ST_GM;
                end
            end
            ST_GM: begin
                if (r_wait && w_unit_done) begin
                    n_wait  = 1'b0;
                    n_gm    = w_mul_p[127:0];
                    n_ax    = 2'd0;
                    n_state = ST_NUM;
                end
            end
            ST_NUM: begin
                if (r_wait && w_unit_done) begin
                    n_wait  = 1'b0;
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (r_wait && w_unit_done) begin
                    n_wait       = 1'b0;
                    n_acc[r_ax]  = sat_add64(r_acc[r_ax], from_mag64(r_ng[r_ax], w_q));
                    if (r_ax == 2'd2) begin
                        n_state = ST_OUT;
                    end else begin
                        n_ax    = r_ax + 2'd1;
                        n_state = ST_NUM;
                    end
                end
            end
            ST_ADT: begin
                if (r_wait && w_unit_done) begin
                    n_wait  = 1'b0;
                    n_adt   = from_mag64(r_acc[r_ax][63], w_mulq);
                    n_state = ST_T;
                end
            end
            ST_T: begin
                if (r_wait && w_unit_done) begin
                    n_wait      = 1'b0;
                    n_half      = from_mag64(w_t[63], mag64(w_t) >> 1);
                    n_vel[r_ax] = sat_add64(r_vel[r_ax], r_adt);
                    n_state     = ST_VDT;
                end
            end
            ST_VDT: begin
                if (r_wait && w_unit_done) begin
                    n_wait      = 1'b0;
                    n_pos[r_ax] = sat_add64(sat_add64(r_pos[r_ax], w_vdt), r_half);
                    n_acc[r_ax] = '0;
                    if (r_ax == 2'd2) begin
                        n_state = ST_OUT;
                    end else begin
                        n_ax    = r_ax + 2'd1;
                        n_state = ST_ADT;
                    end
                end
            end
            ST_OUT: begin
                if (w_load_out) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_wait    <= 1'b0;
            r_ax      <= 2'd0;
            r_active  <= 1'b1;
            r_o_valid <= 1'b0;
            r_grav    <= 63'd4294967296;
            r_soft    <= 63'd42949673;
            r_dt      <= 63'd42949673;
            for (int k = 0; k < 3; k++) begin
                r_pos[k] <= '0;
                r_vel[k] <= '0;
                r_acc[k] <= '0;
            end
        end else begin
            r_state  <= n_state;
            r_wait   <= n_wait;
            r_ax     <= n_ax;
            r_active <= n_active;
            r_pos    <= n_pos;
            r_vel    <= n_vel;
            r_acc    <= n_acc;
            if (w_load_out) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                case (t_cfg_index'(i_cfg_index))
                    CFG_GRAVITY:   r_grav <= i_cfg_data;
                    CFG_SOFTENING: r_soft <= i_cfg_data;
                    CFG_TIME_STEP: r_dt   <= i_cfg_data;
                    default:       r_grav <= r_grav;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_m    <= n_m;
        r_ng   <= n_ng;
        r_mass <= n_mass;
        r_sum  <= n_sum;
        r_s    <= n_s;
        r_r    <= n_r;
        r_den  <= n_den;
        r_gm   <= n_gm;
        r_adt  <= n_adt;
        r_half <= n_half;
        if (w_load_out) begin
            r_o_pos    <= r_pos;
            r_o_vel    <= r_vel;
            r_o_acc    <= r_acc;
            r_o_active <= r_active;
        end
    end

    sgi_mul #(.AW(MA), .BW(MB)) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start.mul),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .o_done  (w_mul_done),
        .o_p     (w_mul_p)
    );

    sgi_sqrt #(.W(64)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start.sqrt),
        .i_x     ({64'd0, r_s} << FRACTION_BITS),
        .o_done  (w_sqrt_done),
        .o_root  (w_root)
    );

    sgi_div #(.DW(128), .QW(64)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start.div),
        .i_num   (w_mul_p),
        .i_den   (r_den),
        .o_done  (w_div_done),
        .o_q     (w_q)
    );

    assign o_valid     = r_o_valid;
    assign o_pos_x     = r_o_pos[0];
    assign o_pos_y     = r_o_pos[1];
    assign o_pos_z     = r_o_pos[2];
    assign o_vel_x     = r_o_vel[0];
    assign o_vel_y     = r_o_vel[1];
    assign o_vel_z     = r_o_vel[2];
    assign o_acc_x     = r_o_acc[0];
    assign o_acc_y     = r_o_acc[1];
    assign o_acc_z     = r_o_acc[2];
    assign o_is_active = r_o_active;
endmodule

[hdl/sgi_checker.sv]
// ---------------------------------------------------------------------------
// sgi_checker
// Port-level properties of the gravity integrator, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sgi_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [63:0] o_acc_x,
    input logic        o_is_active
);
    // A stalled result keeps its contents.
    `SGI_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_acc_x) && $stable(o_is_active))

    // Only one item is in work: after an accept the input side is closed.
    `SGI_ASSERT_NEXT(a_one_item, i_clk, i_rst_n, i_valid && o_ready, !o_ready)

    // A new result appears together with the return to idle.
    `SGI_ASSERT_SAME(a_publish_idle, i_clk, i_rst_n, $rose(o_valid), o_ready)
endmodule

bind softened_gravity_integrator_unit sgi_checker u_sgi_checker (.*);

[bench/tb_softened_gravity_integrator_unit.sv]
// ---------------------------------------------------------------------------
// tb_softened_gravity_integrator_unit
// Self-checking bench for the softened-gravity body integrator. A bit-exact
// predictor tracks the body state and configuration, and every returned item
// is compared field by field against the oldest predicted state. Stimulus
// covers directed corner cases, several configuration settings and a long
// random run with bursty input and a stalling receiver.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_softened_gravity_integrator_unit import sgi_pkg::*;;

    localparam int FB = 32;
    localparam int IDLE_LIMIT = 20000;
    localparam logic [63:0] ONES = {64{1'b1}};
    localparam logic [62:0] CFG_MAX = {63{1'b1}};

    typedef struct {
        logic [63:0] pos [3];
        logic [63:0] vel [3];
        logic [63:0] acc [3];
        logic        act;
    } t_body;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [1:0]  i_op = OP_PULL;
    logic signed [63:0] i_in_x = '0, i_in_y = '0, i_in_z = '0;
    logic signed [63:0] i_in_vx = '0, i_in_vy = '0, i_in_vz = '0;
    logic [62:0] i_other_mass = '0;
    logic        i_other_active = 1'b0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic signed [63:0] o_pos_x, o_pos_y, o_pos_z;
    logic signed [63:0] o_vel_x, o_vel_y, o_vel_z;
    logic signed [63:0] o_acc_x, o_acc_y, o_acc_z;
    logic        o_is_active;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = CFG_GRAVITY;
    logic [62:0] i_cfg_data = '0;

    softened_gravity_integrator_unit dut (.*);

    always #4 i_clk = ~i_clk;

    // Predicted body state and configuration.
    t_body       body;
    logic [62:0] grav_g, soft_eps, step_dt;
    t_body       pending_states[$];
    int          fail_count = 0;
    int          idle_cycles = 0;
    int          burst_left = 0;
    int          hold_cycles = 0;
    int          rx_mode = 0;

    function automatic logic [63:0] mag(input logic [63:0] x);
        return x[63] ? (64'd0 - x) : x;
    endfunction

    function automatic logic [63:0] from_mag(input logic neg, input logic [63:0] m);
        if (neg) return (m >= SIGN64) ? SIGN64 : (64'd0 - m);
        return (m > MAX64) ? MAX64 : m;
    endfunction

    function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] r;
        r = a + b;
        if (a[63] == b[63] && r[63] != a[63]) return a[63] ? SIGN64 : MAX64;
        return r;
    endfunction

    function automatic logic [63:0] fixed_mul(input logic [63:0] x, input logic [62:0] y);
        logic [127:0] p;
        p = ({64'd0, mag(x)} * {65'd0, y}) >> FB;
        return from_mag(x[63], (p[127:64] != 0) ? ONES : p[63:0]);
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [127:0] x);
        logic [63:0]  r, t;
        logic [127:0] tt;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            t = r | (64'd1 << b);
            tt = {64'd0, t};
            if (tt * tt <= x) r = t;
        end
        return r;
    endfunction

    function automatic void accumulate_pull(input logic [63:0] other [3],
                                            input logic [62:0] mass);
        logic [63:0]  delta [3];
        logic         neg [3];
        logic [255:0] sum, sw, den, gm, quo;
        logic [63:0]  s, r;
        sum = '0;
        for (int i = 0; i < 3; i++) begin
            neg[i] = !($signed(other[i]) >= $signed(body.pos[i]));
            delta[i] = neg[i] ? body.pos[i] - other[i] : other[i] - body.pos[i];
            sum = sum + ({192'd0, delta[i]} * {192'd0, delta[i]});
        end
        sw = (sum >> FB) + {193'd0, soft_eps};
        s = (sw[255:64] != 0) ? ONES : sw[63:0];
        if (s == 0) return;
        r = int_sqrt({64'd0, s} << FB);
        den = {192'd0, s} * {192'd0, r};
        gm = {193'd0, grav_g} * {193'd0, mass};
        for (int i = 0; i < 3; i++) begin
            quo = (gm * {192'd0, delta[i]}) / den;
            body.acc[i] = sat_add(body.acc[i],
                from_mag(neg[i], (quo[255:64] != 0) ? ONES : quo[63:0]));
        end
    endfunction

    function automatic void advance_body();
        logic [63:0] adt, t, half;
        for (int i = 0; i < 3; i++) begin
            adt = fixed_mul(body.acc[i], step_dt);
            t = fixed_mul(adt, step_dt);
            half = from_mag(t[63], mag(t) >> 1);
            body.vel[i] = sat_add(body.vel[i], adt);
            body.pos[i] = sat_add(sat_add(body.pos[i], fixed_mul(body.vel[i], step_dt)), half);
            body.acc[i] = '0;
        end
    endfunction

    function automatic void predict_item();
        logic [63:0] other [3];
        other[0] = i_in_x; other[1] = i_in_y; other[2] = i_in_z;
        case (t_op'(i_op))
            OP_PULL:    if (body.act && i_other_active) accumulate_pull(other, i_other_mass);
            OP_ADVANCE: if (body.act) advance_body();
            OP_LOAD: begin
                body.pos = other;
                body.vel[0] = i_in_vx; body.vel[1] = i_in_vy; body.vel[2] = i_in_vz;
                for (int i = 0; i < 3; i++) body.acc[i] = '0;
                body.act = 1'b1;
            end
            OP_DEACT:   body.act = 1'b0;
            default: ;
        endcase
        pending_states = {pending_states, body};
    endfunction

    function automatic void check_field(input string name, input logic [63:0] exp_v,
                                        input logic [63:0] act_v);
        if (exp_v !== act_v) begin
            fail_count++;
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, act_v);
        end
    endfunction

    // Predictor, checker and watchdog, all sampled at the rising edge.
    always @(posedge i_clk) begin
        t_body e;
        if (!i_rst_n) begin
            grav_g = 63'd4294967296;
            soft_eps = 63'd42949673;
            step_dt = 63'd42949673;
            for (int i = 0; i < 3; i++) begin
                body.pos[i] = '0; body.vel[i] = '0; body.acc[i] = '0;
            end
            body.act = 1'b1;
        end else begin
            idle_cycles++;
            if (i_cfg_valid && o_cfg_ready) begin
                idle_cycles = 0;
                case (t_cfg_index'(i_cfg_index))
                    CFG_GRAVITY:   grav_g = i_cfg_data;
                    CFG_SOFTENING: soft_eps = i_cfg_data;
                    CFG_TIME_STEP: step_dt = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_valid && o_ready) begin
                idle_cycles = 0;
                predict_item();
            end
            if (o_valid && i_ready) begin
                idle_cycles = 0;
                if (pending_states.size() == 0) begin
                    fail_count++;
                    $display("%0t: item returned with none expected", $time);
                end else begin
                    e = pending_states.pop_front();
                    check_field("pos_x", e.pos[0], o_pos_x);
                    check_field("pos_y", e.pos[1], o_pos_y);
                    check_field("pos_z", e.pos[2], o_pos_z);
                    check_field("vel_x", e.vel[0], o_vel_x);
                    check_field("vel_y", e.vel[1], o_vel_y);
                    check_field("vel_z", e.vel[2], o_vel_z);
                    check_field("acc_x", e.acc[0], o_acc_x);
                    check_field("acc_y", e.acc[1], o_acc_y);
                    check_field("acc_z", e.acc[2], o_acc_z);
                    check_field("is_active", {63'd0, e.act}, {63'd0, o_is_active});
                end
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // Receiver: switches between stall patterns, and honors a forced hold-off.
    always @(negedge i_clk) begin
        if ($urandom_range(0, 199) == 0) rx_mode = $urandom_range(0, 2);
        if (hold_cycles > 0) begin
            hold_cycles--;
            i_ready = 1'b0;
        end else begin
            case (rx_mode)
                0: i_ready = 1'b1;
                1: i_ready = ($urandom_range(0, 1) == 1);
                default: i_ready = ($urandom_range(0, 4) == 0);
            endcase
        end
    end

    task automatic send_item(input t_op op, input logic [63:0] x, input logic [63:0] y,
                             input logic [63:0] z, input logic [63:0] vx,
                             input logic [63:0] vy, input logic [63:0] vz,
                             input logic [62:0] mass, input logic other_on);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(0, 2) != 0) begin
                @(negedge i_clk);
                i_valid = 1'b0;
                repeat ($urandom_range(0, 15)) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        i_valid = 1'b1;
        i_op = op;
        i_in_x = x; i_in_y = y; i_in_z = z;
        i_in_vx = vx; i_in_vy = vy; i_in_vz = vz;
        i_other_mass = mass;
        i_other_active = other_on;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (pending_states.size() != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_index idx, input logic [62:0] data);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic set_config(input logic [62:0] g, input logic [62:0] eps,
                              input logic [62:0] dt);
        write_reg(CFG_GRAVITY, g);
        write_reg(CFG_SOFTENING, eps);
        write_reg(CFG_TIME_STEP, dt);
    endtask

    function automatic logic [63:0] rand_coord();
        logic signed [63:0] v;
        v = $signed({$urandom, $urandom});
        case ($urandom_range(0, 9))
            0: return v;
            1: return ($urandom_range(0, 1) == 1) ? SIGN64 : MAX64;
            default: return v >>> $urandom_range(14, 58);
        endcase
    endfunction

    function automatic logic [62:0] rand_mass();
        logic [62:0] m;
        m = 63'({$urandom, $urandom});
        if ($urandom_range(0, 7) == 0) return m;
        return m >> $urandom_range(20, 60);
    endfunction

    task automatic send_random(input int unsigned deact_weight);
        int unsigned pick;
        t_op op;
        pick = $urandom_range(0, 99);
        if (pick < 50) op = OP_PULL;
        else if (pick < 75) op = OP_ADVANCE;
        else if (pick < 100 - deact_weight) op = OP_LOAD;
        else op = OP_DEACT;
        send_item(op, rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                  rand_coord(), rand_coord(), rand_mass(), $urandom_range(0, 7) != 0);
    endtask

    task automatic test_directed();
        // Inactive pair, then inactive body: pull and advance change nothing.
        send_item(OP_PULL, 64'd1 << 33, 0, 0, 0, 0, 0, 63'd1 << 32, 1'b0);
        send_item(OP_DEACT, 0, 0, 0, 0, 0, 0, 0, 1'b0);
        send_item(OP_PULL, 64'd1 << 33, 0, 0, 0, 0, 0, 63'd1 << 32, 1'b1);
        send_item(OP_ADVANCE, 0, 0, 0, 0, 0, 0, 0, 1'b0);
        // Load extremes, then saturating steps and pulls.
        send_item(OP_LOAD, MAX64, SIGN64, 0, MAX64, SIGN64, ONES, CFG_MAX, 1'b1);
        send_item(OP_PULL, SIGN64, MAX64, ONES, 0, 0, 0, CFG_MAX, 1'b1);
        send_item(OP_ADVANCE, ONES, ONES, ONES, ONES, ONES, ONES, CFG_MAX, 1'b1);
        send_item(OP_PULL, 0, 0, 0, 0, 0, 0, 0, 1'b1);
        send_item(OP_LOAD, 0, 0, 0, 64'd1 << 32, 0, 0, 0, 1'b0);
        // Coincident bodies: only softening keeps the pull finite.
        send_item(OP_PULL, 0, 0, 0, 0, 0, 0, CFG_MAX, 1'b1);
        send_item(OP_PULL, 64'd1 << 32, -(64'd1 << 32), 64'd3 << 31, 0, 0, 0,
                  63'd1 << 40, 1'b1);
        send_item(OP_PULL, 64'd1, 0, 0, 0, 0, 0, 63'd1 << 62, 1'b1);
        send_item(OP_ADVANCE, 0, 0, 0, 0, 0, 0, 0, 1'b1);
        send_item(OP_ADVANCE, 0, 0, 0, 0, 0, 0, 0, 1'b1);
        wait_drained();
    endtask

    task automatic test_config_extremes();
        // Zero softening with coincident bodies gives a zero softened distance.
        set_config(63'd1 << 32, 63'd0, CFG_MAX);
        send_item(OP_LOAD, 64'd5 << 32, 0, 0, 0, 0, 0, 0, 1'b1);
        send_item(OP_PULL, 64'd5 << 32, 0, 0, 0, 0, 0, 63'd1 << 32, 1'b1);
        send_item(OP_PULL, 64'd7 << 32, 64'd1 << 20, 0, 0, 0, 0, 63'd1 << 32, 1'b1);
        send_item(OP_ADVANCE, 0, 0, 0, 0, 0, 0, 0, 1'b1);
        wait_drained();
        set_config(CFG_MAX, CFG_MAX, 63'd0);
        write_reg(CFG_UNUSED, CFG_MAX);
        send_item(OP_PULL, SIGN64, 0, MAX64, 0, 0, 0, CFG_MAX, 1'b1);
        send_item(OP_PULL, 64'd1 << 36, 0, 0, 0, 0, 0, 63'd1 << 32, 1'b1);
        send_item(OP_ADVANCE, 0, 0, 0, 0, 0, 0, 0, 1'b1);
        wait_drained();
        set_config(63'd0, 63'd1, 63'd1);
        send_item(OP_PULL, 64'd3, 64'd4, 0, 0, 0, 0, CFG_MAX, 1'b1);
        send_item(OP_ADVANCE, 0, 0, 0, 0, 0, 0, 0, 1'b1);
        wait_drained();
    endtask

    task automatic test_backpressure();
        // Receiver holds off long enough that the input side must stall.
        @(negedge i_clk);
        hold_cycles = 300;
        repeat (8) send_item($urandom_range(0, 1) ? OP_LOAD : OP_DEACT, rand_coord(),
                             rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                             rand_coord(), rand_mass(), 1'b1);
        send_item(OP_ADVANCE, 0, 0, 0, 0, 0, 0, 0, 1'b1);
        wait_drained();
    endtask

    task automatic test_random();
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: set_config(63'd4294967296, 63'd42949673, 63'd42949673);
                1: set_config(63'd1 << $urandom_range(20, 44), 63'd0,
                              63'd1 << $urandom_range(24, 34));
                2: set_config(CFG_MAX, CFG_MAX, CFG_MAX);
                default: set_config(63'({$urandom, $urandom} >> $urandom_range(16, 40)),
                                    63'({$urandom, $urandom} >> $urandom_range(20, 50)),
                                    63'({$urandom, $urandom} >> $urandom_range(26, 40)));
            endcase
            send_item(OP_LOAD, rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                      rand_coord(), rand_coord(), 0, 1'b1);
            for (int n = 0; n < 310; n++) send_random((phase == 3) ? 30 : 8);
            wait_drained();
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_config_extremes();
        test_backpressure();
        test_random();
        repeat (50) @(negedge i_clk);
        if (fail_count == 0 && pending_states.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+hdl
hdl/sgi_pkg.sv
hdl/sgi_mul.sv
hdl/sgi_sqrt.sv
hdl/sgi_div.sv
hdl/softened_gravity_integrator_unit.sv
hdl/sgi_checker.sv
bench/tb_softened_gravity_integrator_unit.sv
